@@ src/uera_pkg.sv @@
// Shared types and constants for the ultrasonic echo range averager.
// Used by uera_div and ultrasonic_echo_range_averager_top; no dependencies.
package uera_pkg;

   localparam int TS_W      = 32;   // echo timestamp width
   localparam int TOTAL_W   = 32;   // flight time accumulator width
   localparam int COUNT_W   = 8;    // sample count and divisor width
   localparam int DIST_W    = 40;   // distance result width
   localparam int UM_PER_US = 172;  // round-trip micrometers per microsecond
   localparam int DIV_STEPS = DIST_W;
   localparam int DIVCNT_W  = $clog2(DIV_STEPS + 1);

   typedef logic [TS_W-1:0]    ts_type;
   typedef logic [TOTAL_W-1:0] total_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [DIST_W-1:0]  dist_type;

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

@@ src/uera_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on uera_pkg for widths and the status struct.
module uera_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  uera_pkg::dist_type  dividend,
   input  uera_pkg::count_type divisor,
   output uera_pkg::dist_type  quotient,
   output uera_pkg::div_sts_type sts
);
   import uera_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DIVCNT_W-1:0] cnt_ff, cnt_in;
   logic [COUNT_W:0]    rem_ff, rem_in;
   dist_type            quo_ff, quo_in;
   count_type           dvs_ff, dvs_in;

   logic [COUNT_W:0]    shifted;
   logic [COUNT_W:0]    diff;
   logic                ge;

   assign shifted = {rem_ff[COUNT_W-1:0], quo_ff[DIST_W-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIVCNT_W'(DIV_STEPS);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in = ge ? diff : shifted;
         quo_in = {quo_ff[DIST_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIVCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

@@ src/ultrasonic_echo_range_averager_top.sv @@
// Ultrasonic echo range averager: pulse width accumulation and result sequencer.
// Depends on uera_pkg and uera_div.
//
// Usage:
//   req_* carries echo line change events, each a 32-bit microsecond timestamp.
//   Events alternate between pulse start and pulse end, starting with a start.
//   rsp_* carries one averaged distance in micrometers each time the number of
//   completed pulses reaches samples_per_result (0 acts as 1).
//   csr_* writes samples_per_result (reset value 8); write only while idle.
// Sequence:
//   An event that completes no average is absorbed; req_tready stays high.
//   An event that completes an average runs these steps: accumulate the total,
//   scale the total by 172, divide in the bit-serial divider (one quotient
//   bit a cycle, then a registered done flag), then load the output register.
//   req_tready is low meanwhile; the result appears on rsp_* after the load.
// Reset: synchronous; clears the pulse phase, total, count, divider and output valid.
// Stall: the result holds in the output register until rsp_tready; a further
//   item is still accepted, but a new result waits in the sequencer until the
//   output register frees, with req_tready low.
module ultrasonic_echo_range_averager_top (
   input  logic                 clock,
   input  logic                 reset,
   // req_tdata: [31:0] timestamp_us
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  uera_pkg::ts_type     req_tdata,
   // rsp_tdata: [39:0] distance_um
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output uera_pkg::dist_type   rsp_tdata,
   // csr_data: [7:0] samples_per_result
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  uera_pkg::count_type  csr_data
);
   import uera_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]  state_ff, state_in;
   count_type   spr_ff, spr_in;
   logic        await_ff, await_in;
   ts_type      start_ff, start_in;
   total_type   total_ff, total_in;
   count_type   count_ff, count_in;
   total_type   hit_total_ff, hit_total_in;
   count_type   dvs_ff, dvs_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   dist_type    rsp_tdata_ff, rsp_tdata_in;

   logic        req_acc;
   count_type   target;
   ts_type      width;
   total_type   total_next;
   count_type   count_next;
   dist_type    scaled;
   logic        div_start;
   dist_type    quotient;
   div_sts_type div_sts;
   logic        out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign target     = (spr_ff == '0) ? COUNT_W'(1) : spr_ff;
   assign width      = req_tdata - start_ff;
   assign scaled     = DIST_W'(hit_total_ff) * DIST_W'(UM_PER_US);
   assign div_start  = (state_ff == ST_MUL);
   assign out_free   = ~rsp_tvalid_ff | rsp_tready;

   always_comb begin
      // pulse end adds width and bumps count; pulse start only latches time
      total_next = total_ff;
      count_next = count_ff;
      if (await_ff) begin
         total_next = total_ff + TOTAL_W'(width);
         count_next = count_ff + 1'b1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      spr_in        = spr_ff;
      await_in      = await_ff;
      start_in      = start_ff;
      total_in      = total_ff;
      count_in      = count_ff;
      hit_total_in  = hit_total_ff;
      dvs_in        = dvs_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;

      if (csr_valid) begin
         spr_in = csr_data;
      end
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               await_in = ~await_ff;
               if (!await_ff) begin
                  start_in = req_tdata;
               end
               if (count_next == target) begin
                  hit_total_in = total_next;
                  dvs_in       = target;
                  total_in     = '0;
                  count_in     = '0;
                  state_in     = ST_MUL;
               end else begin
                  total_in = total_next;
                  count_in = count_next;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_sts.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold the quotient until the output register frees
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = quotient;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         spr_ff        <= COUNT_W'(8);
         await_ff      <= 1'b0;
         start_ff      <= '0;
         total_ff      <= '0;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         spr_ff        <= spr_in;
         await_ff      <= await_in;
         start_ff      <= start_in;
         total_ff      <= total_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      hit_total_ff <= hit_total_in;
      dvs_ff       <= dvs_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   uera_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (scaled),
      .divisor  (dvs_ff),
      .quotient (quotient),
      .sts      (div_sts)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide phase");

   a_cleared_on_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (count_ff == '0) && (total_ff == '0))
      else $error("total or count not cleared when an average completes");

   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |=> div_sts.busy && (state_ff == ST_DIV))
      else $error("divider did not start after scaling");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && out_free |=> rsp_tvalid && (state_ff == ST_IDLE))
      else $error("result not loaded into the output register");

endmodule

@@ verif/uera_range_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the ultrasonic echo range averager. It watches the echo, result
// and setting channels, predicts each averaged distance and compares it.
// Depends on uera_pkg.
module uera_range_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  uera_pkg::ts_type    req_tdata,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  uera_pkg::dist_type  rsp_tdata,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  uera_pkg::count_type csr_data,
   output int unsigned         fail_count,
   output int unsigned         pending,
   output int unsigned         results_checked
);
   import uera_pkg::*;

   localparam int unsigned REPORT_MAX = 10;

   count_type   avg_target;
   logic        echo_awaiting_end;
   ts_type      echo_start_us;
   total_type   flight_sum_us;
   count_type   pulse_count;
   dist_type    dist_expected_q[$];
   int unsigned mismatch_tally;
   int unsigned result_tally;

   task automatic check_distance(input dist_type got);
      dist_type want;
      if (dist_expected_q.size() == 0) begin
         mismatch_tally++;
         if (mismatch_tally <= REPORT_MAX)
            $display("[%0t] unexpected distance result: actual %0d um", $time, got);
      end else begin
         want = dist_expected_q.pop_front();
         result_tally++;
         if (got !== want) begin
            mismatch_tally++;
            if (mismatch_tally <= REPORT_MAX)
               $display("[%0t] distance_um mismatch: expected %0d, actual %0d",
                        $time, want, got);
         end
      end
   endtask

   // Starts and ends alternate; the count is compared after every edge.
   task automatic predict_echo(input ts_type now);
      count_type   target;
      logic [63:0] scaled;
      target = (avg_target == '0) ? count_type'(1) : avg_target;
      if (echo_awaiting_end) begin
         flight_sum_us     = flight_sum_us + total_type'(now - echo_start_us);
         pulse_count       = pulse_count + 1'b1;
         echo_awaiting_end = 1'b0;
      end else begin
         echo_start_us     = now;
         echo_awaiting_end = 1'b1;
      end
      if (pulse_count == target) begin
         scaled = 64'(flight_sum_us) * 64'(UM_PER_US);
         dist_expected_q.push_back(dist_type'(scaled / 64'(target)));
         flight_sum_us = '0;
         pulse_count   = '0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         avg_target        = count_type'(8);
         echo_awaiting_end = 1'b0;
         echo_start_us     = '0;
         flight_sum_us     = '0;
         pulse_count       = '0;
         mismatch_tally    = 0;
         result_tally      = 0;
         dist_expected_q.delete();
         fail_count      <= 0;
         pending         <= 0;
         results_checked <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_distance(rsp_tdata);
         if (csr_valid && csr_ready) avg_target = csr_data;
         if (req_tvalid && req_tready) predict_echo(req_tdata);
         fail_count      <= mismatch_tally;
         pending         <= dist_expected_q.size();
         results_checked <= result_tally;
      end
   end

endmodule

@@ verif/tb_ultrasonic_echo_range_averager_top.sv @@
`timescale 1ns / 1ps
// Top-level testbench for ultrasonic_echo_range_averager_top: drives echo items
// and sample-count settings, stalls the result side, and gives the verdict.
// Depends on uera_pkg, the block under test and uera_range_checker.
module tb_ultrasonic_echo_range_averager_top;
   import uera_pkg::*;

   localparam int unsigned ITEM_TARGET   = 1400;
   localparam int unsigned SETTLE_CYCLES = 48;
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;

   typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_HOLD} ready_mode_type;

   logic      clock      = 1'b0;
   logic      reset      = 1'b1;
   logic      req_tvalid = 1'b0;
   logic      req_tready;
   ts_type    req_tdata  = '0;
   logic      rsp_tvalid;
   logic      rsp_tready = 1'b0;
   dist_type  rsp_tdata;
   logic      csr_valid  = 1'b0;
   logic      csr_ready;
   count_type csr_data   = '0;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned results_checked;
   int unsigned items_sent;
   int unsigned cfg_writes;
   int unsigned burst_left;
   int unsigned cycle_count;
   int unsigned ready_left;
   ready_mode_type ready_mode = RDY_ALWAYS;
   ts_type      echo_clock_us;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ultrasonic_echo_range_averager_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   uera_range_checker range_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked)
   );

   // Result-side back-pressure: switch between stall patterns every stretch.
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         ready_left = $urandom_range(1, 80);
      end else begin
         ready_left = ready_left - 1;
      end
      case (ready_mode)
         RDY_ALWAYS: rsp_tready <= 1'b1;
         RDY_COIN:   rsp_tready <= ($urandom_range(0, 1) == 1);
         RDY_SPARSE: rsp_tready <= ($urandom_range(0, 7) == 0);
         default:    rsp_tready <= 1'b0;
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
         $display("tb_ultrasonic_echo_range_averager_top: FAIL");
         $finish;
      end
   end

   // Send one echo item; the sender works in bursts separated by random gaps.
   task automatic send_echo(input ts_type ts);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 40);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ts;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      items_sent++;
   endtask

   task automatic send_pulse(input ts_type start, input ts_type width);
      send_echo(start);
      send_echo(start + width);
   endtask

   // Drop valid, wait out every due result, then let the block go quiet.
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_samples_per_result(input count_type value);
      settle_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cfg_writes++;
   endtask

   function automatic ts_type pick_width();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return ts_type'($urandom);
         2:       return ~ts_type'($urandom_range(0, 1000));
         default: return ts_type'($urandom_range(100, 38000));
      endcase
   endfunction

   function automatic count_type pick_samples();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll < 12)       return count_type'($urandom_range(2, 8));
      else if (roll < 15)  return count_type'($urandom_range(9, 40));
      else if (roll == 15) return '0;
      else if (roll == 16) return count_type'(255);
      else                 return count_type'(1);
   endfunction

   task automatic run_random_phase(input count_type spr, input int unsigned pulses);
      write_samples_per_result(spr);
      for (int unsigned i = 0; i < pulses; i++) begin
         if ($urandom_range(0, 15) == 0) echo_clock_us = ts_type'($urandom);
         else echo_clock_us = echo_clock_us + ts_type'($urandom_range(100, 60000));
         send_pulse(echo_clock_us, pick_width());
      end
      // a lone edge flips the start/end phase for the next phase
      if ($urandom_range(0, 5) == 0) send_echo(ts_type'($urandom));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset setting of eight pulses: zero, wrapped and full-scale widths
      send_pulse(32'h0000_0000, 32'h0000_0000);
      send_pulse(32'hFFFF_FFFF, 32'h0000_0006);
      send_pulse(32'h0000_0001, 32'hFFFF_FFFF);
      send_pulse(32'h1234_5678, 32'd580);
      send_pulse(32'hA5A5_A5A5, 32'd23200);
      send_pulse(32'h5A5A_5A5A, 32'd1);
      send_pulse(32'h7FFF_FFFF, 32'h8000_0000);
      send_pulse(32'hFFFF_0000, 32'd400);

      write_samples_per_result(8'd1);
      send_pulse(32'h0000_0000, 32'hFFFF_FFFF);   // largest distance
      write_samples_per_result(8'd0);              // acts as one
      send_pulse(32'd100, 32'd250);
      write_samples_per_result(8'd2);              // total wraps past 32 bits
      send_pulse(32'h0000_0000, 32'hFFFF_FFFF);
      send_pulse(32'h0000_0005, 32'hFFFF_FFFF);

      // count already equal to the new setting: emit on the next start
      write_samples_per_result(8'd3);
      send_pulse(32'h0001_0000, 32'd1500);
      send_pulse(32'h0002_0000, 32'd2600);
      write_samples_per_result(8'd2);
      send_echo(32'h0BAD_F00D);

      // count left above the new setting has to wrap before it matches
      run_random_phase(8'd200, 120);
      run_random_phase(8'd60, 200);

      while (items_sent < ITEM_TARGET)
         run_random_phase(pick_samples(), $urandom_range(10, 60));

      settle_idle();
      $display("covered %0d echo items, %0d distance results, %0d sample-count writes",
               items_sent, results_checked, cfg_writes);
      $display("%0d mismatches, %0d results never arrived", fail_count, pending);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_ultrasonic_echo_range_averager_top: PASS");
      end else begin
         $display("tb_ultrasonic_echo_range_averager_top: FAIL");
      end
      $finish;
   end

endmodule

@@ ultrasonic_echo_range_averager_top.f @@
src/uera_pkg.sv
src/uera_div.sv
src/ultrasonic_echo_range_averager_top.sv
verif/uera_range_checker.sv
verif/tb_ultrasonic_echo_range_averager_top.sv
